FILE: hdl/slcfr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slcfr_pkg
// Shared types, constants and the CRC-16 byte update for the frame receiver.
// ---------------------------------------------------------------------------
package slcfr_pkg;

   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_TOPBIT = 16'h8000;

   // Configuration register indexes.
   localparam logic [1:0] REG_SYNC_FIRST    = 2'd0;
   localparam logic [1:0] REG_SYNC_SECOND   = 2'd1;
   localparam logic [1:0] REG_CRC_SEED      = 2'd2;
   localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd3;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_CRC_GOOD = 2'd1,
      KIND_CRC_BAD  = 2'd2
   } kind_type;

   typedef enum logic [7:0] {
      PH_HUNT    = 8'b0000_0001,
      PH_SYNC2   = 8'b0000_0010,
      PH_TYPE    = 8'b0000_0100,
      PH_LENHI   = 8'b0000_1000,
      PH_LENLO   = 8'b0001_0000,
      PH_PAYLOAD = 8'b0010_0000,
      PH_CRCHI   = 8'b0100_0000,
      PH_CRCLO   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [15:0] crc_seed;
      logic [15:0] payload_limit;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [7:0]  frame_kind;
      logic [15:0] frame_length;
   } result_type;

   // Byte-wide unrolled CRC-16, MSB first, no reflection.
   function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOPBIT) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: hdl/sync_length_crc16_frame_receiver.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sync_length_crc16_frame_receiver
// Hunts for a two-byte sync, parses type, length, payload and CRC-16.
// ---------------------------------------------------------------------------
// The receiver takes one byte per clock while req_tready is high and
// registers its result, if any, for the rsp side: each payload byte, then
// one end beat per frame that passes the length limit, telling whether the
// CRC-16 (polynomial 0x1021, seed from crc_seed) matched. The byte-wide CRC
// update and the frame state machine sit between the state registers and a
// result register backed by a one-entry skid stage, so req_tready only drops
// after the consumer has stalled for two results. Configuration writes are
// taken every cycle and should be made while no frame is in progress.
module sync_length_crc16_frame_receiver
   import slcfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input beat.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Result beat.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] payload_byte, [15:8] frame_kind,
                                    // [31:16] frame_length
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   // Register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type    cfg_ff;
   result_type parse_res;
   result_type head;
   logic       space;
   logic       beat_valid;

   assign csr_ready  = 1'b1;
   assign req_tready = space;
   assign beat_valid = req_tvalid && space;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first    <= 8'hAA;
         cfg_ff.sync_second   <= 8'h55;
         cfg_ff.crc_seed      <= 16'hFFFF;
         cfg_ff.payload_limit <= 16'd1024;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SYNC_FIRST:    cfg_ff.sync_first    <= csr_data[7:0];
            REG_SYNC_SECOND:   cfg_ff.sync_second   <= csr_data[7:0];
            REG_CRC_SEED:      cfg_ff.crc_seed      <= csr_data;
            REG_PAYLOAD_LIMIT: cfg_ff.payload_limit <= csr_data;
            default: begin
            end
         endcase
      end
   end

   slcfr_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat_byte  (req_tdata),
      .cfg        (cfg_ff),
      .res        (parse_res)
   );

   slcfr_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (parse_res),
      .space     (space),
      .head      (head),
      .pop_ready (rsp_tready)
   );

   assign rsp_tvalid = head.valid;
   assign rsp_tuser  = head.kind;
   assign rsp_tdata  = {head.frame_length, head.frame_kind, head.payload_byte};

endmodule

FILE: hdl/slcfr_parse.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slcfr_parse
// Frame state machine and running CRC; turns one accepted byte into at most
// one result in the same cycle.
// ---------------------------------------------------------------------------
module slcfr_parse
   import slcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       beat_valid,
   input  logic [7:0] beat_byte,
   input  cfg_type    cfg,
   output result_type res
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_kind_ff, held_kind_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [15:0] bytes_taken_ff, bytes_taken_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  crc_high_ff, crc_high_in;

   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic [15:0] length_full;
   logic [15:0] taken_next;

   assign crc_base    = (phase_ff == PH_TYPE) ? cfg.crc_seed : running_crc_ff;
   assign crc_next    = crc_add_byte(crc_base, beat_byte);
   assign length_full = {held_length_ff[15:8], beat_byte};
   assign taken_next  = bytes_taken_ff + 16'd1;

   always_comb begin
      phase_in       = phase_ff;
      held_kind_in   = held_kind_ff;
      held_length_in = held_length_ff;
      bytes_taken_in = bytes_taken_ff;
      running_crc_in = running_crc_ff;
      crc_high_in    = crc_high_ff;
      res            = '0;
      res.frame_kind   = held_kind_ff;
      res.frame_length = held_length_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (beat_byte == cfg.sync_first) begin
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (beat_byte == cfg.sync_second) begin
               phase_in = PH_TYPE;
            end else if (beat_byte != cfg.sync_first) begin
               phase_in = PH_HUNT;
            end
         end
         PH_TYPE: begin
            held_kind_in   = beat_byte;
            running_crc_in = crc_next;
            phase_in       = PH_LENHI;
         end
         PH_LENHI: begin
            held_length_in = {beat_byte, 8'h00};
            running_crc_in = crc_next;
            phase_in       = PH_LENLO;
         end
         PH_LENLO: begin
            held_length_in = length_full;
            running_crc_in = crc_next;
            bytes_taken_in = '0;
            if (length_full > cfg.payload_limit) begin
               phase_in = PH_HUNT;
            end else if (length_full == 16'd0) begin
               phase_in = PH_CRCHI;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            running_crc_in   = crc_next;
            bytes_taken_in   = taken_next;
            res.valid        = beat_valid;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = beat_byte;
            if (taken_next == held_length_ff) begin
               phase_in = PH_CRCHI;
            end
         end
         PH_CRCHI: begin
            crc_high_in = beat_byte;
            phase_in    = PH_CRCLO;
         end
         PH_CRCLO: begin
            res.valid = beat_valid;
            res.kind  = ({crc_high_ff, beat_byte} == running_crc_ff) ?
                        KIND_CRC_GOOD : KIND_CRC_BAD;
            phase_in  = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else if (beat_valid) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_kind_ff   <= 8'h00;
         held_length_ff <= 16'h0000;
         bytes_taken_ff <= 16'h0000;
         running_crc_ff <= 16'h0000;
         crc_high_ff    <= 8'h00;
      end else if (beat_valid) begin
         held_kind_ff   <= held_kind_in;
         held_length_ff <= held_length_in;
         bytes_taken_ff <= bytes_taken_in;
         running_crc_ff <= running_crc_in;
         crc_high_ff    <= crc_high_in;
      end
   end

endmodule

FILE: hdl/slcfr_outbuf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slcfr_outbuf
// Result register with a skid entry, so the input side keeps moving while a
// finished result waits for the consumer.
// ---------------------------------------------------------------------------
module slcfr_outbuf
   import slcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type push,
   output logic       space,
   output result_type head,
   input  logic       pop_ready
);

   logic       out_valid_ff, skid_valid_ff;
   result_type out_data_ff, skid_data_ff;
   logic       pop;

   assign space = !skid_valid_ff;
   assign pop   = out_valid_ff && pop_ready;

   always_comb begin
      head       = out_data_ff;
      head.valid = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push.valid) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push.valid) begin
         if (!out_valid_ff || pop) begin
            out_data_ff <= push;
         end else begin
            skid_data_ff <= push;
         end
      end
   end

endmodule
